/* src/bslc_pkg.sv */
// bslc_pkg: shared types, codes and constants of the battery status LED controller
// no dependencies
`default_nettype none

package bslc_pkg;

  localparam int unsigned MV_W      = 13;
  localparam int unsigned HP_W      = 15;
  localparam int unsigned FC_W      = 4;
  localparam int unsigned LAYER_W   = 8;
  localparam int unsigned COL_W     = 24;
  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned REQ_W     = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK       = 3'd0,
    REQ_SAMPLE     = 3'd1,
    REQ_READ_FAIL  = 3'd2,
    REQ_CONNECT    = 3'd3,
    REQ_DISCONNECT = 3'd4,
    REQ_LAYER      = 3'd5
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOOD_MV   = 3'd0,
    CFG_FAIR_MV   = 3'd1,
    CFG_WEAK_MV   = 3'd2,
    CFG_SLOW_HALF = 3'd3,
    CFG_FAST_HALF = 3'd4,
    CFG_FLASH_CNT = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2,
    MODE_FLASH = 2'd3
  } mode_e;

  // register reset values
  localparam logic [MV_W-1:0] GOOD_MV_RST   = MV_W'(3700);
  localparam logic [MV_W-1:0] FAIR_MV_RST   = MV_W'(3500);
  localparam logic [MV_W-1:0] WEAK_MV_RST   = MV_W'(3300);
  localparam logic [HP_W-1:0] SLOW_HALF_RST = HP_W'(500);
  localparam logic [HP_W-1:0] FAST_HALF_RST = HP_W'(250);
  localparam logic [FC_W-1:0] FLASH_CNT_RST = FC_W'(4);

  // colours as r, g, b bytes
  localparam logic [COL_W-1:0] COL_GREEN  = 24'h00FF00;
  localparam logic [COL_W-1:0] COL_YELLOW = 24'hFFFF00;
  localparam logic [COL_W-1:0] COL_RED    = 24'hFF0000;
  localparam logic [COL_W-1:0] COL_BLUE   = 24'h0000FF;
  localparam logic [COL_W-1:0] COL_WHITE  = 24'hFFFFFF;
  localparam logic [COL_W-1:0] COL_PURPLE = 24'h800080;
  localparam logic [COL_W-1:0] COL_CYAN   = 24'h00FFFF;
  localparam logic [COL_W-1:0] COL_ORANGE = 24'hFFA500;

  typedef struct packed {
    mode_e              mode;
    logic [COL_W-1:0]   target;
    logic               phase_on;
    logic [FC_W-1:0]    flashes;
    logic               running;
    logic [HP_W-1:0]    tick_cnt;
    logic [HP_W-1:0]    half;
    logic               batt_known;
    logic               link_up;
    logic [LAYER_W-1:0] layer;
    logic               shutdown;
    logic [COL_W-1:0]   shown;
    logic               lit;
    logic               power;
  } led_state_t;

endpackage

`default_nettype wire

/* src/battery_status_led_controller.sv */
// Battery status LED controller: every event updates the indicator state in one pass
// depends on bslc_pkg
//
// Usage: events arrive on the in_* channel (valid/ready). req_type_i selects a
// millisecond tick, a battery sample, a failed read, a link connect or disconnect,
// or a layer change. Every event produces exactly one result on the out_* channel:
// the colour last driven, whether the LED is lit, the LED power enable and the
// shutdown latch.
// The result of an event accepted at an edge is valid after that edge.
// Throughput is one event per cycle unless the receiver stalls; the state update
// and the result register are loaded at the same edge by one combinational pass.
// When the receiver stalls, the result holds and in_ready_o stays low until the
// pending result is transferred; in_ready_o is high whenever the result register is
// empty or being taken in the same cycle.
// The user must write thresholds, half periods and the flash count (cfg_we_i,
// cfg_index_i, cfg_data_i) only while no event is in flight; the block does not
// enforce this. Reset clears all indicator state (LED dark, power off, no shutdown)
// and restores the register defaults. The shutdown latch is cleared only by reset.
`default_nettype none

module battery_status_led_controller (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [bslc_pkg::REQ_W-1:0]        req_type_i,
  input  wire  [bslc_pkg::MV_W-1:0]         battery_mv_i,
  input  wire                               connect_failed_i,
  input  wire  [bslc_pkg::LAYER_W-1:0]      layer_number_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [7:0]                        led_red_o,
  output logic [7:0]                        led_green_o,
  output logic [7:0]                        led_blue_o,
  output logic                              led_lit_o,
  output logic                              power_enabled_o,
  output logic                              shutdown_latched_o,
  input  wire                               cfg_we_i,
  input  wire  [bslc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [bslc_pkg::CFG_W-1:0]        cfg_data_i
);
  import bslc_pkg::*;

  logic [MV_W-1:0] good_mv_q, fair_mv_q, weak_mv_q;
  logic [HP_W-1:0] slow_half_q, fast_half_q;
  logic [FC_W-1:0] flash_cnt_q;

  led_state_t st_q, st_d;
  logic       out_valid_q;
  logic       in_xfer;
  logic [HP_W:0] tick_sum;

  // light the target colour unless shut down
  function automatic led_state_t f_drive(led_state_t s);
    led_state_t r;
    r = s;
    if (r.shutdown) begin
      r.lit = 1'b0;
    end else begin
      r.power = 1'b1;
      r.shown = r.target;
      r.lit   = 1'b1;
    end
    return r;
  endfunction

  function automatic led_state_t f_apply(led_state_t s);
    led_state_t r;
    r = s;
    case (r.mode)
      MODE_ON: r = f_drive(r);
      MODE_BLINK: begin
        if (r.phase_on) r = f_drive(r);
        else r.lit = 1'b0;
      end
      MODE_FLASH: begin
        if (r.flashes != '0) begin
          if (r.phase_on) begin
            r = f_drive(r);
          end else begin
            r.lit     = 1'b0;
            r.flashes = r.flashes - FC_W'(1);
          end
        end else begin
          // flash budget used up: cut power for good
          r.lit      = 1'b0;
          r.power    = 1'b0;
          r.shutdown = 1'b1;
          r.mode     = MODE_NONE;
        end
      end
      default: r.lit = 1'b0;
    endcase
    return r;
  endfunction

  // colour from link and layer, only while no battery reading is known
  function automatic led_state_t f_link_layer(led_state_t s);
    led_state_t r;
    r = s;
    if (!r.batt_known) begin
      if (r.link_up) begin
        r.target = COL_BLUE;
        r.mode   = MODE_ON;
      end else begin
        case (r.layer)
          8'd0: begin r.target = COL_WHITE;  r.mode = MODE_ON; end
          8'd1: begin r.target = COL_PURPLE; r.mode = MODE_ON; end
          8'd2: begin r.target = COL_CYAN;   r.mode = MODE_ON; end
          8'd3: begin r.target = COL_ORANGE; r.mode = MODE_ON; end
          default: r.mode = MODE_NONE;
        endcase
      end
      r = f_apply(r);
    end
    return r;
  endfunction

  function automatic led_state_t f_blink_start(led_state_t s, logic [HP_W-1:0] half);
    led_state_t r;
    r = s;
    r.running  = 1'b1;
    r.tick_cnt = '0;
    r.half     = half;
    return r;
  endfunction

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign tick_sum   = {1'b0, st_q.tick_cnt} + (HP_W+1)'(1);

  always_comb begin
    st_d = st_q;
    case (req_type_i)
      REQ_TICK: begin
        if (st_q.running) begin
          // a zero half period toggles on every tick
          if (tick_sum >= {1'b0, st_q.half}) begin
            st_d.tick_cnt = '0;
            st_d.phase_on = !st_q.phase_on;
            st_d = f_apply(st_d);
          end else begin
            st_d.tick_cnt = tick_sum[HP_W-1:0];
          end
        end
      end
      REQ_SAMPLE: begin
        st_d.batt_known = (battery_mv_i != '0);
        if (st_q.shutdown) begin
          st_d.mode     = MODE_NONE;
          st_d.running  = 1'b0;
          st_d.phase_on = 1'b0;
          st_d.tick_cnt = '0;
        end else if (battery_mv_i > good_mv_q) begin
          st_d.target   = COL_GREEN;
          st_d.mode     = MODE_ON;
          st_d.running  = 1'b0;
          st_d.phase_on = 1'b0;
          st_d.tick_cnt = '0;
          st_d = f_apply(st_d);
        end else if (battery_mv_i > fair_mv_q) begin
          st_d.target = COL_YELLOW;
          st_d.mode   = MODE_BLINK;
          st_d = f_blink_start(st_d, slow_half_q);
        end else if (battery_mv_i > weak_mv_q) begin
          st_d.target = COL_RED;
          st_d.mode   = MODE_BLINK;
          st_d = f_blink_start(st_d, fast_half_q);
        end else begin
          // flash count reloads only on entry into critical mode
          if (st_q.mode != MODE_FLASH) st_d.flashes = flash_cnt_q;
          st_d.target = COL_RED;
          st_d.mode   = MODE_FLASH;
          st_d = f_blink_start(st_d, fast_half_q);
        end
        st_d = f_link_layer(st_d);
      end
      REQ_READ_FAIL: st_d = f_link_layer(st_q);
      REQ_CONNECT: begin
        if (!connect_failed_i) begin
          st_d.link_up = 1'b1;
          if (!st_q.batt_known) begin
            st_d.target = COL_BLUE;
            st_d.mode   = MODE_ON;
            st_d = f_apply(st_d);
          end
        end
      end
      REQ_DISCONNECT: begin
        st_d.link_up = 1'b0;
        if (!st_q.batt_known) begin
          st_d.mode = MODE_NONE;
          st_d = f_apply(st_d);
        end
      end
      REQ_LAYER: begin
        st_d.layer = layer_number_i;
        if (!st_q.batt_known && !st_q.link_up && !st_q.shutdown) begin
          st_d = f_link_layer(st_d);
        end
      end
      default: st_d = st_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        st_q        <= st_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_mv_q   <= GOOD_MV_RST;
      fair_mv_q   <= FAIR_MV_RST;
      weak_mv_q   <= WEAK_MV_RST;
      slow_half_q <= SLOW_HALF_RST;
      fast_half_q <= FAST_HALF_RST;
      flash_cnt_q <= FLASH_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GOOD_MV:   good_mv_q   <= cfg_data_i[MV_W-1:0];
        CFG_FAIR_MV:   fair_mv_q   <= cfg_data_i[MV_W-1:0];
        CFG_WEAK_MV:   weak_mv_q   <= cfg_data_i[MV_W-1:0];
        CFG_SLOW_HALF: slow_half_q <= cfg_data_i[HP_W-1:0];
        CFG_FAST_HALF: fast_half_q <= cfg_data_i[HP_W-1:0];
        CFG_FLASH_CNT: flash_cnt_q <= cfg_data_i[FC_W-1:0];
        default: ;
      endcase
    end
  end

  // state only changes on a transfer, so it doubles as the result register
  assign out_valid_o        = out_valid_q;
  assign led_red_o          = st_q.shown[23:16];
  assign led_green_o        = st_q.shown[15:8];
  assign led_blue_o         = st_q.shown[7:0];
  assign led_lit_o          = st_q.lit;
  assign power_enabled_o    = st_q.power;
  assign shutdown_latched_o = st_q.shutdown;

  a_shutdown_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.shutdown |=> st_q.shutdown)
    else $error("shutdown latch cleared without reset");

  a_no_power_in_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.shutdown |-> !st_q.power)
    else $error("led power enabled after shutdown");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_q)
    else $error("accepted event produced no result");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.tick_cnt == '0) || (st_q.tick_cnt < st_q.half))
    else $error("tick counter beyond half period");

endmodule

`default_nettype wire
